@@ hw/rtl/cwsg_pkg.sv @@
// Shared types and constants of the crank wheel signal generator.
package cwsg_pkg;

  typedef enum logic [2:0] {
    REG_DEGREE_PERIOD  = 3'd0,
    REG_TOOTH_DEGREES  = 3'd1,
    REG_GAP_DEGREES    = 3'd2,
    REG_TEETH_PER_TURN = 3'd3,
    REG_MISSING_TEETH  = 3'd4,
    REG_START_LEVEL    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] degree_period;
    logic [7:0]  tooth_degrees;
    logic [7:0]  gap_degrees;
    logic [6:0]  teeth_per_turn;
    logic [6:0]  missing_teeth;
    logic        start_level;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    degree_period:  16'd2666,
    tooth_degrees:  8'd3,
    gap_degrees:    8'd3,
    teeth_per_turn: 7'd60,
    missing_teeth:  7'd2,
    start_level:    1'b1
  };

  typedef struct packed {
    reg_idx_e    index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic advance;
  } tick_t;

  typedef struct packed {
    logic       sensor_level;
    logic       degree_strobe;
    logic [7:0] half_tooth_index;
    logic       in_tooth;
  } result_t;

  // Visible wheel position, before the current update.
  typedef struct packed {
    logic [7:0] index;
    logic       tooth;
    logic       level;
  } wheel_t;

endpackage

@@ hw/rtl/cwsg_stream_if.sv @@
// Valid/ready channel carrying one payload of a given type.
interface cwsg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/cwsg_wheel.sv @@
// Wheel state: degree timer, phase counter, half-tooth index and sensor level.
module cwsg_wheel
  import cwsg_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  logic    advance_i,
  input  logic    load_level_i,
  input  logic    load_value_i,
  output result_t result_o,
  output wheel_t  cur_o
);

  logic [TIMER_WIDTH-1:0] tick_q, tick_d;
  logic [TIMER_WIDTH-1:0] period_cmp;
  logic [7:0] deg_q, deg_d, deg_inc, limit;
  logic [7:0] idx_q, idx_d, idx_inc, twice_teeth;
  logic       tooth_q, tooth_d;
  logic       level_q, level_d;
  logic       strobe;

  assign period_cmp  = TIMER_WIDTH'(cfg_i.degree_period);
  assign deg_inc     = deg_q + 8'd1;
  assign idx_inc     = idx_q + 8'd1;
  assign twice_teeth = {cfg_i.teeth_per_turn, 1'b0};
  assign limit       = tooth_q ? cfg_i.tooth_degrees : cfg_i.gap_degrees;

  always_comb begin
    tick_d  = tick_q;
    deg_d   = deg_q;
    idx_d   = idx_q;
    tooth_d = tooth_q;
    level_d = level_q;
    strobe  = 1'b0;
    if (advance_i) begin
      if (tick_q == period_cmp) begin
        tick_d = '0;
        strobe = 1'b1;
        if (deg_inc < limit) begin
          deg_d = deg_inc;
        end else begin
          tooth_d = ~tooth_q;
          deg_d   = '0;
          idx_d   = (idx_inc > twice_teeth) ? 8'd1 : idx_inc;
          // toggle unless inside the missing-tooth window at the end of the turn
          if (10'(twice_teeth) >= 10'({cfg_i.missing_teeth, 1'b0}) + 10'(idx_d)) begin
            level_d = ~level_q;
          end
        end
      end else begin
        tick_d = tick_q + TIMER_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      deg_q   <= '0;
      idx_q   <= 8'd1;
      tooth_q <= 1'b1;
      level_q <= CfgReset.start_level;
    end else if (load_level_i) begin
      level_q <= load_value_i;
    end else if (step_i) begin
      tick_q  <= tick_d;
      deg_q   <= deg_d;
      idx_q   <= idx_d;
      tooth_q <= tooth_d;
      level_q <= level_d;
    end
  end

  assign result_o = '{
    sensor_level:     level_d,
    degree_strobe:    strobe,
    half_tooth_index: idx_d,
    in_tooth:         tooth_d
  };
  assign cur_o = '{index: idx_q, tooth: tooth_q, level: level_q};

endmodule

@@ hw/rtl/crank_wheel_signal_generator_top.sv @@
// Top level of the crank wheel signal generator with its channels and registers.
// Each input transfer is one timer tick (advance = 1) or a hold (advance = 0), and
// each produces exactly one result: the sensor level, the degree strobe, the
// half-tooth index and the tooth/gap flag after that tick. One tick is taken every
// clock cycle while out_o is ready; each tick passes an input register and a result
// register around the wheel update. A stalled result holds while one further tick
// waits in the input register.
// Registers are written through the configuration channel, which is always ready;
// writing start_level also loads the sensor level. Write only while idle.
module crank_wheel_signal_generator_top
  import cwsg_pkg::*;
#(
  parameter int TIMER_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cwsg_stream_if.sink   cfg_i,
  cwsg_stream_if.sink   in_i,
  cwsg_stream_if.source out_o
);

  cfg_t    cfg_q;
  cfg_wr_t cfg_wr;
  tick_t   in_q;
  logic    in_vld_q;
  result_t out_q, result;
  logic    out_vld_q;
  logic    move;
  logic    cfg_write;
  logic    load_level;
  wheel_t  cur;

  assign cfg_wr     = cfg_i.data;
  assign cfg_i.ready = 1'b1;
  assign cfg_write  = cfg_i.valid;
  assign load_level = cfg_write && (cfg_wr.index == REG_START_LEVEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_write) begin
      unique case (cfg_wr.index)
        REG_DEGREE_PERIOD:  cfg_q.degree_period  <= cfg_wr.data;
        REG_TOOTH_DEGREES:  cfg_q.tooth_degrees  <= cfg_wr.data[7:0];
        REG_GAP_DEGREES:    cfg_q.gap_degrees    <= cfg_wr.data[7:0];
        REG_TEETH_PER_TURN: cfg_q.teeth_per_turn <= cfg_wr.data[6:0];
        REG_MISSING_TEETH:  cfg_q.missing_teeth  <= cfg_wr.data[6:0];
        REG_START_LEVEL:    cfg_q.start_level    <= cfg_wr.data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // advance the input register into the result register when the latter is free
  assign move       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (move) begin
        in_vld_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (move) begin
      out_q <= result;
    end
  end

  cwsg_wheel #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_wheel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .step_i       (move),
    .advance_i    (in_q.advance),
    .load_level_i (load_level),
    .load_value_i (cfg_wr.data[0]),
    .result_o     (result),
    .cur_o        (cur)
  );

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  a_hold_no_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && !in_q.advance |-> !result.degree_strobe)
    else $error("degree strobe on a held tick");

  a_position_needs_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && !result.degree_strobe |->
      result.half_tooth_index == cur.index && result.in_tooth == cur.tooth &&
      result.sensor_level == cur.level)
    else $error("wheel position moved without a degree");

  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(move))
    else $error("result valid without a tick transfer");

endmodule
